### hdl/ctf_pkg.sv
// Shared types, constants and the arctangent table for the complementary tilt filter.
// Used by the top level, the CORDIC unit and the constant divider; depends on nothing.
`default_nettype none

package ctf_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int GYRO_FS_W  = 11;
  localparam int DEG_W      = 12;
  localparam int ANGLE_W    = 32;
  localparam int IN_DATA_W  = 5 * SAMPLE_W;
  localparam int OUT_DATA_W = ((2 * DEG_W + 7) / 8) * 8;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [GYRO_FS_W-1:0] GYRO_FS_RESET = 11'd250;
  localparam int OUT_LIMIT = 1200;

  // Gyro step: raw * fs * 2^F / (2^17 * 25) gives the 10 ms increment.
  localparam int GYRO_MAG_W = 27;
  localparam int GYRO_A_W   = 34;
  localparam int GYRO_Q_W   = 30;
  localparam int DIV_SHIFT  = 17;

  // Blend numerator 49*g + acc fits in this signed width for every legal parameter.
  localparam int NUM_W = 41;

  // Constant divider: one quotient digit per cycle
  localparam int DIGIT_W = 4;
  localparam int REM_W   = 6;
  localparam logic [REM_W-1:0] DIV_GYRO  = 6'd25;
  localparam logic [REM_W-1:0] DIV_BLEND = 6'd50;

  // CORDIC vector width and guard bits of the angle accumulator above FRAC_BITS
  localparam int CORDIC_W    = 36;
  localparam int ACC_GUARD_W = 11;

  // atan(2^-i) in degrees with 24 fraction bits
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_FRAC  = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int ATAN_W     = 30;

  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115
  };

  // Table entry rounded half up to fb fraction bits; with fb of 24 or more it is returned unchanged.
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx,
                                                   input int fb);
    logic [ATAN_W:0] t;
    int sh;
    sh = ATAN_FRAC - fb;
    t  = {1'b0, ATAN_TAB[idx]};
    if (sh <= 0) begin
      return ATAN_TAB[idx];
    end
    t = t + ((ATAN_W + 1)'(1) << (sh - 1));
    return ATAN_W'(t >> sh);
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_GYRO,
    S_GYRO_W,
    S_ATAN,
    S_ATAN_W,
    S_MUL,
    S_BLEND,
    S_BLEND_W,
    S_EMIT
  } ctf_state_t;

  typedef struct packed {
    logic start;
    logic by50;
  } ctf_div_ctl_t;

endpackage

`default_nettype wire

### hdl/ctf_cdiv.sv
// Unsigned division by the constant 25 or 50, four quotient bits per cycle.
// Depends on ctf_pkg for widths, divisor constants and the control struct.
`default_nettype none

module ctf_cdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctf_pkg::ctf_div_ctl_t      ctl,
  input  logic [ctf_pkg::NUM_W-1:0]  dividend,
  output logic                       done,
  output logic [ctf_pkg::NUM_W-1:0]  quotient
);
  import ctf_pkg::*;

  localparam int DIGITS = (NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PW     = DIGITS * DIGIT_W;
  localparam int CNT_W  = $clog2(DIGITS);
  localparam int P_W    = REM_W + DIGIT_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    work_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] dv_r;

  logic [P_W-1:0]     part;
  logic [P_W-1:0]     dv_w;
  logic [DIGIT_W-1:0] digit;
  logic [REM_W-1:0]   rem_nxt;

  // The remainder stays below the divisor, so one digit never exceeds 15.
  always_comb begin
    part  = {rem_r, work_r[PW-1 -: DIGIT_W]};
    dv_w  = P_W'(dv_r);
    digit = '0;
    for (int k = 1; k < (1 << DIGIT_W); k++) begin
      if (part >= P_W'(k) * dv_w) begin
        digit = DIGIT_W'(k);
      end
    end
    rem_nxt = REM_W'(part - P_W'(digit) * dv_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIGITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      work_r <= PW'(dividend);
      rem_r  <= '0;
      dv_r   <= ctl.by50 ? DIV_BLEND : DIV_GYRO;
    end else if (busy_r) begin
      work_r <= {work_r[PW-DIGIT_W-1:0], digit};
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = work_r[NUM_W-1:0];

endmodule

`default_nettype wire

### hdl/ctf_cordic.sv
// Vectoring CORDIC for atan2(y, x) in degrees, one rotation per cycle.
// Depends on ctf_pkg for the arctangent table and widths.
`default_nettype none

module ctf_cordic #(
  parameter int FRAC_BITS    = ctf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]           y_in,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]           x_in,
  output logic                                          done,
  output logic signed [FRAC_BITS+ctf_pkg::ACC_GUARD_W-1:0] z_out
);
  import ctf_pkg::*;

  localparam int ZW = FRAC_BITS + ACC_GUARD_W;
  localparam int EW = SAMPLE_W + 1;
  localparam logic signed [ZW-1:0] Z180 = ZW'(64'd180 << FRAC_BITS);

  logic                          run_r;
  logic                          done_r;
  logic [ATAN_IDX_W-1:0]         idx_r;
  logic signed [CORDIC_W-1:0]    x_r;
  logic signed [CORDIC_W-1:0]    y_r;
  logic signed [ZW-1:0]          z_r;

  logic signed [EW-1:0]       x_ext;
  logic signed [EW-1:0]       y_ext;
  logic signed [EW-1:0]       x_abs;
  logic signed [EW-1:0]       y_abs;
  logic                       flip;
  logic signed [ZW-1:0]       z_init;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [ZW-1:0]       ent;
  logic signed [CORDIC_W-1:0] x_nxt;
  logic signed [CORDIC_W-1:0] y_nxt;
  logic signed [ZW-1:0]       z_nxt;
  logic                       last;

  // A vector in the left half plane is turned by 180 degrees first.
  always_comb begin
    x_ext  = {x_in[SAMPLE_W-1], x_in};
    y_ext  = {y_in[SAMPLE_W-1], y_in};
    flip   = x_in[SAMPLE_W-1];
    x_abs  = flip ? -x_ext : x_ext;
    y_abs  = flip ? -y_ext : y_ext;
    z_init = !flip ? '0 : (y_in[SAMPLE_W-1] ? -Z180 : Z180);
  end

  always_comb begin
    xs  = x_r >>> idx_r;
    ys  = y_r >>> idx_r;
    ent = ZW'(atan_entry(idx_r, FRAC_BITS));
    if (y_r[CORDIC_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - ent;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + ent;
    end
    last = (idx_r == ATAN_IDX_W'(CORDIC_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        idx_r <= '0;
        if (y_in == '0) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        idx_r <= idx_r + 1'b1;
        if (last) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= {{(CORDIC_W - EW - 16){x_abs[EW-1]}}, x_abs, 16'b0};
      y_r <= {{(CORDIC_W - EW - 16){y_abs[EW-1]}}, y_abs, 16'b0};
      if (y_in == '0) begin
        z_r <= flip ? Z180 : '0;
      end else begin
        z_r <= z_init;
      end
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

`default_nettype wire

### hdl/complementary_tilt_filter.sv
// Complementary tilt filter top level: sequencer, angle state and stream ports.
// Depends on ctf_pkg, ctf_cdiv and ctf_cordic.
//
// Takes one raw IMU sample per transaction (accelerometer X, Y, Z and gyro X, Y) and
// returns one transaction with pitch and roll in whole degrees, truncated toward zero
// and limited to +-1200. Gyro rates are scaled by cfg_wr_data's full-scale range and
// integrated over 10 ms; each angle is then blended 49/50 with the accelerometer angle.
// A sample is worked on alone, from acceptance to a valid result. The shared constant
// divider runs four divisions per sample, and the CORDIC unit turns one vector per cycle
// for each of the two angles. An angle whose accelerometer X or Y operand is zero skips
// the rotations. The result waits in the emit step for as long as the previous result
// is still held by out_tready. The next sample can be taken in the idle state that
// follows the load, even if the result is still waiting on out_tready. The user must
// write the full-scale register only while no sample is in work; the block itself
// does not enforce it.
`default_nettype none

module complementary_tilt_filter #(
  parameter int FRAC_BITS    = ctf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y: 16 bits each, from bit 0 up
  input  logic [ctf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pitch_deg [11:0], roll_deg [23:12]
  output logic [ctf_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [ctf_pkg::GYRO_FS_W-1:0]     cfg_wr_data
);
  import ctf_pkg::*;

  localparam int ZW  = FRAC_BITS + ACC_GUARD_W;
  localparam int SHL = (FRAC_BITS >= DIV_SHIFT) ? FRAC_BITS - DIV_SHIFT : 0;
  localparam int SHR = (FRAC_BITS >= DIV_SHIFT) ? 0 : DIV_SHIFT - FRAC_BITS;
  localparam int DW  = GYRO_Q_W + 1;
  localparam int GW  = ANGLE_W + 1;
  localparam logic signed [ANGLE_W-1:0] ANG_MAX = {1'b0, {(ANGLE_W - 1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANG_MIN = {1'b1, {(ANGLE_W - 1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] LIM_W   = ANGLE_W'(OUT_LIMIT);
  localparam logic signed [DEG_W-1:0]   DEG_MAX = DEG_W'(OUT_LIMIT);
  localparam logic signed [DEG_W-1:0]   DEG_MIN = -DEG_MAX;

  // Control state
  ctf_state_t state_r, state_nxt;
  logic       lane_r, lane_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [GYRO_FS_W-1:0] fs_r;
  logic signed [ANGLE_W-1:0] pitch_r;
  logic signed [ANGLE_W-1:0] roll_r;

  // Working registers
  logic signed [SAMPLE_W-1:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic signed [DW-1:0]       dp_r, dr_r;
  logic signed [ZW-1:0]       accp_r, accr_r;
  logic signed [NUM_W-1:0]    m49_r;
  logic                       neg_r;
  logic signed [DEG_W-1:0]    outp_r, outr_r;

  // Unit handshakes
  ctf_div_ctl_t         div_ctl;
  logic [NUM_W-1:0]     div_dividend;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quot;
  logic                 cor_start;
  logic                 cor_done;
  logic signed [ZW-1:0] cor_z;
  logic                 accept;
  logic                 emit_go;

  // Datapath
  logic signed [SAMPLE_W-1:0]  g_raw;
  logic signed [GYRO_MAG_W:0]  g_prod;
  logic [GYRO_MAG_W-1:0]       g_mag;
  logic [GYRO_A_W-1:0]         g_a;
  logic signed [DW-1:0]        q_ext;
  logic signed [DW-1:0]        delta;
  logic                        delta_neg;
  logic signed [ANGLE_W-1:0]   ang_sel;
  logic signed [DW-1:0]        dsel;
  logic signed [GW-1:0]        g_sum;
  logic signed [NUM_W-1:0]     g_w;
  logic signed [NUM_W-1:0]     m49;
  logic signed [ZW-1:0]        acc_sel;
  logic signed [NUM_W-1:0]     num;
  logic [NUM_W-1:0]            num_mag;
  logic signed [ANGLE_W-1:0]   blend_res;

  function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [ANGLE_W-1:0] a);
    logic signed [ANGLE_W-1:0] w;
    w = a >>> FRAC_BITS;
    if (a[ANGLE_W-1] && (a[FRAC_BITS-1:0] != '0)) begin
      w = w + ANGLE_W'(1);
    end
    if (w > LIM_W) begin
      return DEG_MAX;
    end
    if (w < -LIM_W) begin
      return DEG_MIN;
    end
    return DEG_W'(w);
  endfunction

  ctf_cdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quot)
  );

  ctf_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .y_in  (lane_r ? ay_r : ax_r),
    .x_in  (az_r),
    .done  (cor_done),
    .z_out (cor_z)
  );

  // Gyro increment: magnitude of raw * fs, scaled, then divided by 25.
  always_comb begin
    g_raw  = lane_r ? gx_r : gy_r;
    g_prod = g_raw * $signed({1'b0, fs_r});
    g_mag  = g_prod[GYRO_MAG_W] ? GYRO_MAG_W'(-g_prod) : GYRO_MAG_W'(g_prod);
    g_a    = (GYRO_A_W'(g_mag) << SHL) >> SHR;
    // Pitch moves against gyro Y, roll with gyro X.
    delta_neg = lane_r ? gx_r[SAMPLE_W-1] : ~gy_r[SAMPLE_W-1];
    q_ext     = {1'b0, div_quot[GYRO_Q_W-1:0]};
    delta     = delta_neg ? -q_ext : q_ext;
  end

  // Blend: 49 * (angle + delta) + accelerometer angle, later divided by 50.
  always_comb begin
    ang_sel = lane_r ? roll_r : pitch_r;
    dsel    = lane_r ? dr_r : dp_r;
    g_sum   = {ang_sel[ANGLE_W-1], ang_sel} + {{(GW - DW){dsel[DW-1]}}, dsel};
    g_w     = {{(NUM_W - GW){g_sum[GW-1]}}, g_sum};
    m49     = (g_w <<< 5) + (g_w <<< 4) + g_w;
    acc_sel = lane_r ? accr_r : accp_r;
    num     = m49_r + {{(NUM_W - ZW){acc_sel[ZW-1]}}, acc_sel};
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    if (!neg_r && (div_quot > NUM_W'(ANG_MAX))) begin
      blend_res = ANG_MAX;
    end else if (neg_r && (div_quot > {{(NUM_W - ANGLE_W){1'b0}}, ANG_MIN})) begin
      blend_res = ANG_MIN;
    end else begin
      blend_res = neg_r ? ANGLE_W'(-div_quot) : ANGLE_W'(div_quot);
    end
  end

  assign div_dividend = (state_r == S_BLEND) ? num_mag : NUM_W'(g_a);
  assign emit_go      = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_GYRO;
      S_GYRO:    state_nxt = S_GYRO_W;
      S_GYRO_W:  if (div_done) state_nxt = lane_r ? S_ATAN : S_GYRO;
      S_ATAN:    state_nxt = S_ATAN_W;
      S_ATAN_W:  if (cor_done) state_nxt = lane_r ? S_MUL : S_ATAN;
      S_MUL:     state_nxt = S_BLEND;
      S_BLEND:   state_nxt = S_BLEND_W;
      S_BLEND_W: if (div_done) state_nxt = lane_r ? S_EMIT : S_MUL;
      S_EMIT:    if (emit_go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready     = 1'b0;
    div_ctl       = '0;
    cor_start     = 1'b0;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE:    in_tready = 1'b1;
      S_GYRO:    div_ctl.start = 1'b1;
      S_GYRO_W:  lane_nxt = lane_r ^ div_done;
      S_ATAN:    cor_start = 1'b1;
      S_ATAN_W:  lane_nxt = lane_r ^ cor_done;
      S_BLEND:   div_ctl = '{start: 1'b1, by50: 1'b1};
      S_BLEND_W: lane_nxt = lane_r ^ div_done;
      S_EMIT:    if (emit_go) out_valid_nxt = 1'b1;
      default:   in_tready = 1'b0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= 1'b0;
      out_valid_r <= 1'b0;
      fs_r        <= GYRO_FS_RESET;
      pitch_r     <= '0;
      roll_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        fs_r <= cfg_wr_data;
      end
      if ((state_r == S_BLEND_W) && div_done) begin
        if (lane_r) begin
          roll_r <= blend_res;
        end else begin
          pitch_r <= blend_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r <= in_tdata[0*SAMPLE_W +: SAMPLE_W];
      ay_r <= in_tdata[1*SAMPLE_W +: SAMPLE_W];
      az_r <= in_tdata[2*SAMPLE_W +: SAMPLE_W];
      gx_r <= in_tdata[3*SAMPLE_W +: SAMPLE_W];
      gy_r <= in_tdata[4*SAMPLE_W +: SAMPLE_W];
    end
    if ((state_r == S_GYRO_W) && div_done) begin
      if (lane_r) begin
        dr_r <= delta;
      end else begin
        dp_r <= delta;
      end
    end
    if ((state_r == S_ATAN_W) && cor_done) begin
      if (lane_r) begin
        accr_r <= cor_z;
      end else begin
        accp_r <= cor_z;
      end
    end
    if (state_r == S_MUL) begin
      m49_r <= m49;
    end
    if (state_r == S_BLEND) begin
      neg_r <= num[NUM_W-1];
    end
    if ((state_r == S_EMIT) && emit_go) begin
      outp_r <= to_deg(pitch_r);
      outr_r <= to_deg(roll_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({outr_r, outp_r});

  // The lane select is back on pitch whenever the sequencer is idle.
  a_lane_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !lane_r)
    else $error("lane select not back on pitch in idle");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == S_GYRO_W) || (state_r == S_BLEND_W)))
    else $error("divider finished while the sequencer was not waiting on it");

  a_cordic_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == S_ATAN_W))
    else $error("CORDIC finished while the sequencer was not waiting on it");

  a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result loaded outside the emit step");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((outp_r <= DEG_MAX) && (outp_r >= DEG_MIN) &&
                     (outr_r <= DEG_MAX) && (outr_r >= DEG_MIN)))
    else $error("output angle beyond the saturation limit");

endmodule

`default_nettype wire
